// ===== sv/fupd_pkg.sv =====
`timescale 1ns / 1ps

package fupd_pkg;

  // Character codes
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowF    = 8'h66;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;

  // Most bytes one input byte can produce
  localparam int unsigned MaxRun = 3;

  // Default depth of the run queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // Decoded bytes caused by one input transfer
  typedef struct packed {
    logic [1:0]             cnt;
    logic [MaxRun-1:0][7:0] data;
    logic                   last;
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CharZero) && (c <= CharNine)) ||
           ((c >= CharLowA) && (c <= CharLowF)) ||
           ((c >= CharUpA)  && (c <= CharUpF));
  endfunction

  // Low four bits of the digit value; letters get ten added
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= CharZero) && (c <= CharNine)) begin
      v = c - CharZero;
    end else if ((c >= CharLowA) && (c <= CharLowF)) begin
      v = c - CharLowA + 8'd10;
    end else if ((c >= CharUpA) && (c <= CharUpF)) begin
      v = c - CharUpA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== sv/fupd_if.sv =====
`timescale 1ns / 1ps

// Raw encoded byte channel
interface fupd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded byte channel
interface fupd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_last,
                  output ready);
endinterface

// ===== sv/fupd_front.sv =====
`timescale 1ns / 1ps

module fupd_front
  import fupd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output run_t       run_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhPct   = 3'b010,
    PhDigit = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  logic       hex;
  logic       f_cnt;
  logic       f_esc;
  logic [7:0] f_byte;

  // Classify the byte as if no escape were pending
  always_comb begin
    hex    = is_hex(in_byte_i);
    f_cnt  = 1'b1;
    f_esc  = 1'b0;
    f_byte = in_byte_i;
    if (in_byte_i == CharPlus) begin
      f_byte = CharSpace;
    end else if (in_byte_i == CharPercent) begin
      f_byte = CharPercent;
      if (!in_last_i) begin
        f_cnt = 1'b0;
        f_esc = 1'b1;
      end
    end
  end

  // Build the run and the next escape phase
  always_comb begin
    run_o      = '0;
    run_o.last = in_last_i;
    held_d     = held_q;
    phase_d    = f_esc ? PhPct : PhIdle;
    case (phase_q)
      PhPct: begin
        if (hex) begin
          if (in_last_i) begin
            run_o.cnt     = 2'd2;
            run_o.data[0] = CharPercent;
            run_o.data[1] = in_byte_i;
            phase_d       = PhIdle;
          end else begin
            held_d  = in_byte_i;
            phase_d = PhDigit;
          end
        end else begin
          run_o.cnt     = {1'b0, f_cnt} + 2'd1;
          run_o.data[0] = CharPercent;
          run_o.data[1] = f_byte;
        end
      end
      PhDigit: begin
        if (hex) begin
          run_o.cnt     = 2'd1;
          run_o.data[0] = {hex_nibble(held_q), hex_nibble(in_byte_i)};
          phase_d       = PhIdle;
        end else begin
          run_o.cnt     = {1'b0, f_cnt} + 2'd2;
          run_o.data[0] = CharPercent;
          run_o.data[1] = held_q;
          run_o.data[2] = f_byte;
        end
      end
      default: begin
        run_o.cnt     = {1'b0, f_cnt};
        run_o.data[0] = f_byte;
      end
    endcase
  end

  // Advance escape state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== sv/fupd_queue.sv =====
`timescale 1ns / 1ps

module fupd_queue
  import fupd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic nonempty_o,
  output run_t head_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  run_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  // Store runs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/fupd_back.sv =====
`timescale 1ns / 1ps

module fupd_back
  import fupd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  run_t       head_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_last_q, string_last_q;
  logic       load;
  logic       sel_last;
  logic [7:0] sel_byte;

  assign load     = head_valid_i && (!valid_q || ready_i);
  assign sel_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o    = load && sel_last;

  // Pick the byte of the head run at the current index
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.data[0];
      2'd1:    sel_byte = head_i.data[1];
      2'd2:    sel_byte = head_i.data[2];
      default: sel_byte = head_i.data[0];
    endcase
  end

  // Hold the output transfer until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= sel_last ? 2'd0 : idx_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q        <= sel_byte;
      run_last_q    <= sel_last;
      string_last_q <= sel_last && head_i.last;
    end
  end

  assign valid_o       = valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign string_last_o = string_last_q;

endmodule

// ===== sv/form_url_percent_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                              Transfer
// in_i      in   in_byte[7:0], in_last                valid && ready
// out_o     out  out_byte[7:0], run_last, string_last valid && ready
//
// One input byte is taken per cycle while the run queue has room; it is decoded
// in that cycle and its 0 to 3 result bytes are queued as one run unless there are none.
// The output stage sends one byte per cycle while out_o.ready stays high.
// Result bytes pass through the run queue and then the output register.
// Reset clears the escape state, the queue and the output valid flag.
// A stalled output fills the queue, after which in_i.ready drops.

module form_url_percent_decoder
  import fupd_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fupd_in_if.sink    in_i,
  fupd_out_if.source out_o
);

  logic accept;
  logic full;
  logic head_valid;
  logic pop;
  run_t run;
  run_t head;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  // Decode and track the escape state
  fupd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .in_last_i (in_i.in_last),
    .run_o     (run)
  );

  // Queue non-empty runs
  fupd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && (run.cnt != 2'd0)),
    .data_i     (run),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (head_valid),
    .head_o     (head)
  );

  // Serialize runs to the output
  fupd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .run_last_o    (out_o.run_last),
    .string_last_o (out_o.string_last)
  );

endmodule
